// File: design/case_control_mutual_information_defines.svh
// Assertion macros used by the controller of the case/control mutual information design.
// The macros expect signals named clk and rst_n in the calling module.
`ifndef CASE_CONTROL_MUTUAL_INFORMATION_DEFINES_SVH
`define CASE_CONTROL_MUTUAL_INFORMATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCMI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccmi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CCMI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccmi assertion failed");

`endif

// File: design/ccmi_pkg.sv
// Shared types, constants and the log2 table generator for the
// case/control mutual information block. No dependencies.
package ccmi_pkg;

    localparam int COUNT_BITS          = 24;
    localparam int LOG_TABLE_BITS_DEF  = 8;
    localparam int CFG_ADDR_BITS       = 1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] Q32_MAX = 32'hFFFF_FFFF;

    localparam logic [CFG_ADDR_BITS-1:0] REG_CASE_TOTAL    = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONTROL_TOTAL = 1'd1;

    // Which probability travels through the p*ln p pipeline.
    localparam logic [1:0] TAG_CASE    = 2'd0;
    localparam logic [1:0] TAG_CONTROL = 2'd1;
    localparam logic [1:0] TAG_SUM     = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] case_count;
        logic [COUNT_BITS-1:0] control_count;
        logic                  last_cell;
    } ccmi_in_t;

    typedef struct packed {
        logic [31:0] mutual_info;
        logic        bad_totals;
    } ccmi_out_t;

    typedef struct packed {
        logic       load_item;
        logic       div_start;
        logic       prob_a;
        logic       prob_b;
        logic       issue;
        logic [1:0] issue_tag;
        logic       derive;
        logic       emit;
    } ccmi_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       res_valid;
        logic [1:0] res_tag;
        logic       last_cell;
        logic       out_free;
    } ccmi_stat_t;

    // log2(1 + i/2^t) in Q0.32 by repeated squaring; the entry past the end is 1.0.
    function automatic logic [32:0] log2_entry(input int unsigned t, input int unsigned i);
        logic [63:0] m;
        logic [32:0] r;
        if (i >= (32'd1 << t)) begin
            return 33'h1_0000_0000;
        end
        m = (64'd1 << 30) + (64'(i) << (30 - t));
        r = '0;
        for (int k = 0; k < 32; k++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd1 << 31)) begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

endpackage

// File: design/ccmi_div.sv
// Restoring divider that forms floor(2^32 / total), one quotient bit a cycle;
// a total of one gives all ones and a total of zero gives zero. Depends on ccmi_pkg.
module ccmi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ccmi_pkg::COUNT_BITS:0] divisor,
    output logic                          done,
    output logic [31:0]                   quotient
);
    import ccmi_pkg::*;

    localparam logic [5:0] DIV_STEPS = 6'd33;

    logic                  busy_reg;
    logic [5:0]            cnt_reg;
    logic                  done_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS:0]   d_reg;
    logic [32:0]           q_reg;
    logic [COUNT_BITS+1:0] rem_sh;
    logic [COUNT_BITS+1:0] rem_sub;
    logic                  ge;

    // The dividend is 2^32: a single one followed by 32 zeros.
    assign rem_sh  = {rem_reg, (cnt_reg == DIV_STEPS)};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[COUNT_BITS:0] : rem_sh[COUNT_BITS:0];
            q_reg   <= {q_reg[31:0], ge};
        end
    end

    assign done = done_reg;

    always_comb
    begin
        if (d_reg == '0)
            quotient = '0;
        else if (d_reg == (COUNT_BITS+1)'(1))
            quotient = Q32_MAX;
        else
            quotient = q_reg[31:0];
    end

endmodule

// File: design/ccmi_plogp.sv
// Nine-stage pipeline computing -p*ln(p) in Q8.40 from p in Q0.32, using an
// interpolated log2 table. Depends on ccmi_pkg.
module ccmi_plogp #(
    parameter int LOG_TABLE_BITS = ccmi_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        issue,
    input  logic [1:0]  issue_tag,
    input  logic [31:0] issue_p,
    output logic        res_valid,
    output logic [1:0]  res_tag,
    output logic [47:0] res
);
    import ccmi_pkg::*;

    localparam int T     = LOG_TABLE_BITS;
    localparam int SH    = 32 - T;
    localparam int TAB_N = (1 << T) + 1;

    logic [32:0] tab [TAB_N];

    logic [8:0]    v_reg;
    logic [1:0]    tag_reg [9];
    logic [31:0]   p_reg [8];
    logic [7:1]    zero_reg;
    logic [5:0]    sft1_reg, sft2_reg, sft3_reg;
    logic [32:0]   t0_2_reg, diff2_reg, t0_3_reg;
    logic [SH-1:0] rem2_reg;
    logic [32+SH:0] prod3_reg;
    logic [37:0]   nlog4_reg;
    logic [63:0]   m5_reg;
    logic [5:0]    int5_reg;
    logic [37:0]   nln6_reg;
    logic [63:0]   plo7_reg;
    logic [5:0]    hi7_reg;
    logic [47:0]   res8_reg;

    logic [31:0]   f2;
    logic [T:0]    ia, ib;
    logic [32:0]   frac4;

    for (genvar g = 0; g < TAB_N; g++)
    begin : g_tab
        assign tab[g] = log2_entry(T, g);
    end

    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] b;
        b = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                b = 5'(i);
        end
        return b;
    endfunction

    // Shifting left by 32-b pushes the leading one out and leaves the mantissa fraction.
    assign f2    = 32'(64'(p_reg[1]) << sft1_reg);
    assign ia    = {1'b0, f2[31:SH]};
    assign ib    = ia + (T+1)'(1);
    assign frac4 = t0_3_reg + 33'(prod3_reg >> SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[7:0], issue};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= issue_tag;
        p_reg[0]   <= issue_p;
        for (int k = 1; k < 9; k++)
            tag_reg[k] <= tag_reg[k-1];
        for (int k = 1; k < 8; k++)
            p_reg[k] <= p_reg[k-1];
        zero_reg[1]   <= (p_reg[0] == '0);
        zero_reg[7:2] <= zero_reg[6:1];

        sft1_reg <= 6'd32 - {1'b0, lead_one(p_reg[0])};

        t0_2_reg  <= tab[ia];
        diff2_reg <= tab[ib] - tab[ia];
        rem2_reg  <= f2[SH-1:0];
        sft2_reg  <= sft1_reg;

        prod3_reg <= {{SH{1'b0}}, diff2_reg} * {33'd0, rem2_reg};
        t0_3_reg  <= t0_2_reg;
        sft3_reg  <= sft2_reg;

        nlog4_reg <= {sft3_reg, 32'd0} - {5'd0, frac4};

        m5_reg   <= 64'(nlog4_reg[31:0]) * 64'(LN2_Q32);
        int5_reg <= nlog4_reg[37:32];

        nln6_reg <= 38'(int5_reg) * 38'(LN2_Q32) + 38'(m5_reg[63:32]);

        plo7_reg <= 64'(p_reg[6]) * 64'(nln6_reg[31:0]);
        hi7_reg  <= nln6_reg[37:32];

        if (zero_reg[7])
            res8_reg <= '0;
        else
            res8_reg <= (48'(38'(p_reg[7]) * 38'(hi7_reg)) << 8) + 48'(plo7_reg >> 24);
    end

    assign res_valid = v_reg[8];
    assign res_tag   = tag_reg[8];
    assign res       = res8_reg;

endmodule

// File: design/ccmi_datapath.sv
// Datapath: configuration registers, probabilities, accumulators and the
// output word register. Depends on ccmi_pkg, ccmi_div and ccmi_plogp.
module ccmi_datapath #(
    parameter int LOG_TABLE_BITS = ccmi_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ccmi_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [ccmi_pkg::COUNT_BITS-1:0]     cfg_data,
    input  ccmi_pkg::ccmi_in_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ccmi_pkg::ccmi_out_t                 out_word,
    input  ccmi_pkg::ccmi_cmd_t                 cmd,
    output ccmi_pkg::ccmi_stat_t                stat
);
    import ccmi_pkg::*;

    localparam logic signed [49:0] ACC_FLOOR = {3'b111, 47'd0};
    localparam logic [47:0]        ACC_MIN   = {1'b1, 47'd0};

    logic [COUNT_BITS-1:0] case_total_reg, control_total_reg;
    logic [31:0]           inv_reg, class_reg;
    logic [47:0]           joint_reg, marg_reg;
    logic [COUNT_BITS-1:0] opa_reg, opb_reg;
    logic                  last_reg;
    logic [31:0]           pa_reg, pb_reg;
    logic [47:0]           csum_reg;
    logic                  out_valid_reg;
    ccmi_out_t             out_word_reg;

    logic [COUNT_BITS:0]    total;
    logic                   total_zero;
    logic                   div_done;
    logic [31:0]            quotient;
    logic [COUNT_BITS-1:0]  mul_op;
    logic [COUNT_BITS+31:0] pm;
    logic [31:0]            p_sat;
    logic [32:0]            ps_raw;
    logic [31:0]            ps;
    logic [31:0]            issue_p;
    logic                   res_valid;
    logic [1:0]             res_tag;
    logic [47:0]            res;
    logic [48:0]            cs;
    logic [31:0]            class_new;
    logic signed [49:0]     r;
    logic [31:0]            mi;
    logic                   out_free;

    function automatic logic [47:0] acc_sub(input logic [47:0] acc, input logic [47:0] term);
        logic signed [49:0] d;
        d = $signed({acc[47], acc[47], acc}) - $signed({2'b00, term});
        if (d < ACC_FLOOR)
            return ACC_MIN;
        return d[47:0];
    endfunction

    assign total      = {1'b0, case_total_reg} + {1'b0, control_total_reg};
    assign total_zero = (total == '0);

    ccmi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (total),
        .done     (div_done),
        .quotient (quotient)
    );

    // One multiplier serves both counts on consecutive cycles.
    assign mul_op = cmd.prob_b ? opb_reg : opa_reg;
    assign pm     = (COUNT_BITS+32)'(mul_op) * (COUNT_BITS+32)'(inv_reg);
    assign p_sat  = (|pm[COUNT_BITS+31:32]) ? Q32_MAX : pm[31:0];
    assign ps_raw = {1'b0, pa_reg} + {1'b0, pb_reg};
    assign ps     = ps_raw[32] ? Q32_MAX : ps_raw[31:0];

    always_comb
    begin
        case (cmd.issue_tag)
            TAG_CASE:    issue_p = pa_reg;
            TAG_CONTROL: issue_p = pb_reg;
            TAG_SUM:     issue_p = ps;
            default:     issue_p = '0;
        endcase
    end

    ccmi_plogp #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_plogp (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (cmd.issue),
        .issue_tag (cmd.issue_tag),
        .issue_p   (issue_p),
        .res_valid (res_valid),
        .res_tag   (res_tag),
        .res       (res)
    );

    assign cs        = {1'b0, csum_reg} + {1'b0, res};
    assign class_new = (|cs[48:40]) ? Q32_MAX : cs[39:8];

    assign r  = $signed({10'd0, class_reg, 8'd0})
              + $signed({{2{joint_reg[47]}}, joint_reg})
              - $signed({{2{marg_reg[47]}}, marg_reg});
    assign mi = (total_zero || r[49]) ? '0 : ((|r[49:40]) ? Q32_MAX : r[39:8]);

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_total_reg    <= '0;
            control_total_reg <= '0;
            inv_reg           <= '0;
            class_reg         <= '0;
            joint_reg         <= '0;
            marg_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_CASE_TOTAL:    case_total_reg    <= cfg_data;
                    REG_CONTROL_TOTAL: control_total_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (div_done)
                inv_reg <= quotient;
            if (res_valid)
            begin
                if (cmd.derive)
                begin
                    if (res_tag == TAG_CONTROL)
                        class_reg <= class_new;
                end
                else if (res_tag == TAG_SUM)
                    marg_reg <= acc_sub(marg_reg, res);
                else
                    joint_reg <= acc_sub(joint_reg, res);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                joint_reg     <= '0;
                marg_reg      <= '0;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            opa_reg <= case_total_reg;
            opb_reg <= control_total_reg;
        end
        else if (cmd.load_item)
        begin
            opa_reg  <= in_word.case_count;
            opb_reg  <= in_word.control_count;
            last_reg <= in_word.last_cell;
        end
        if (cmd.prob_a)
            pa_reg <= p_sat;
        if (cmd.prob_b)
            pb_reg <= p_sat;
        if (res_valid && cmd.derive && res_tag == TAG_CASE)
            csum_reg <= res;
        if (cmd.emit)
        begin
            out_word_reg.mutual_info <= mi;
            out_word_reg.bad_totals  <= total_zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign stat.div_done  = div_done;
    assign stat.res_valid = res_valid;
    assign stat.res_tag   = res_tag;
    assign stat.last_cell = last_reg;
    assign stat.out_free  = out_free;

endmodule

// File: design/ccmi_ctrl.sv
// Controller state machine that sequences derivation after configuration
// writes and the processing of each cell. Depends on ccmi_pkg and the defines header.
`include "case_control_mutual_information_defines.svh"

module ccmi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ccmi_pkg::ccmi_stat_t stat,
    output ccmi_pkg::ccmi_cmd_t  cmd
);
    import ccmi_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_GO   = 4'd1;
    localparam logic [3:0] ST_DIV_WAIT = 4'd2;
    localparam logic [3:0] ST_PROB_A   = 4'd3;
    localparam logic [3:0] ST_PROB_B   = 4'd4;
    localparam logic [3:0] ST_ISSUE_A  = 4'd5;
    localparam logic [3:0] ST_ISSUE_B  = 4'd6;
    localparam logic [3:0] ST_ISSUE_S  = 4'd7;
    localparam logic [3:0] ST_WAIT     = 4'd8;
    localparam logic [3:0] ST_RESULT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       pending_reg, pending_next;
    logic       derive_reg, derive_next;
    logic       last_tag_seen;

    assign in_stall      = !(state_reg == ST_IDLE && !pending_reg);
    assign last_tag_seen = stat.res_valid &&
                           (stat.res_tag == (derive_reg ? TAG_CONTROL : TAG_SUM));

    // A write during a derivation leaves the request pending, so it is redone.
    assign pending_next = cfg_wr_en || (pending_reg && state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        derive_next = derive_reg;
        cmd         = '0;
        cmd.derive  = derive_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    state_next  = ST_DIV_GO;
                    derive_next = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    derive_next   = 1'b0;
                    state_next    = ST_PROB_A;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_PROB_A;
            end
            ST_PROB_A:
            begin
                cmd.prob_a = 1'b1;
                state_next = ST_PROB_B;
            end
            ST_PROB_B:
            begin
                cmd.prob_b = 1'b1;
                state_next = ST_ISSUE_A;
            end
            ST_ISSUE_A:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_tag = TAG_CASE;
                state_next    = ST_ISSUE_B;
            end
            ST_ISSUE_B:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_tag = TAG_CONTROL;
                state_next    = derive_reg ? ST_WAIT : ST_ISSUE_S;
            end
            ST_ISSUE_S:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_tag = TAG_SUM;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (last_tag_seen)
                begin
                    if (!derive_reg && stat.last_cell)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            derive_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            derive_reg  <= derive_next;
        end
    end

    `CCMI_ASSERT_NXT(a_accept_starts_item, in_valid && !in_stall, state_reg == ST_PROB_A)
    `CCMI_ASSERT_NXT(a_pending_starts_derive, state_reg == ST_IDLE && pending_reg, state_reg == ST_DIV_GO)
    `CCMI_ASSERT_IMP(a_result_only_for_items, state_reg == ST_RESULT, !derive_reg)

endmodule

// File: design/case_control_mutual_information.sv
// Case/control mutual information over a streamed contingency table.
// Input channel: one word per table cell (case count, control count, last flag),
//   accepted when in_valid is high and in_stall is low.
// Output channel: one word per table, issued on the last cell, holding the
//   mutual information in nats (unsigned Q0.32) and a flag for zero totals.
// Configuration: case_total (index 0) and control_total (index 1) are written
//   through cfg_wr_en/cfg_addr/cfg_data. Each write rederives the reciprocal of
//   the total with a bit-serial divider and H(Y) through the log pipeline;
//   in_stall stays high meanwhile.
// A new cell is accepted only once the three probabilities of the previous
//   cell have passed in turn through the nine-stage p*ln(p) pipeline.
// The output word is registered once the last cell's sum term has left the pipeline and the output register is free.
// When out_stall holds the output word, the block keeps accepting cells until
//   the next last cell, which then waits for the output register to free up.
// Reset clears the totals, the derived terms and both accumulators.
module case_control_mutual_information #(
    parameter int LOG_TABLE_BITS = ccmi_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [ccmi_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [ccmi_pkg::COUNT_BITS-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ccmi_pkg::ccmi_in_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ccmi_pkg::ccmi_out_t                out_word
);
    import ccmi_pkg::*;

    ccmi_cmd_t  cmd;
    ccmi_stat_t stat;

    ccmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ccmi_datapath #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for case_control_mutual_information.
// Depends on ccmi_pkg for the word types and register indexes; predicts the
// mutual information of each streamed table in fixed point and checks every output word.
module tb_top;
    import ccmi_pkg::*;

    localparam int TAB_BITS = LOG_TABLE_BITS_DEF;
    localparam int TAB_SHIFT = 32 - TAB_BITS;
    localparam longint SUM_FLOOR = -(longint'(1) << 47);
    localparam bit [63:0] SAT32 = 64'hFFFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [COUNT_BITS-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    ccmi_in_t                 in_word;
    logic                     out_valid;
    logic                     out_stall;
    ccmi_out_t                out_word;

    int fail_count = 0;
    int tx_idle_pct = 11;
    int rx_idle_pct = 85;
    int rx_hold = 0;
    int cells_sent = 0;

    case_control_mutual_information dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    task automatic report(input string msg);
        $display("error at %0t: %s", $time, msg);
        fail_count++;
    endtask

    class mi_tracker;
        bit [63:0] log2_tab[(1 << TAB_BITS) + 1];
        bit [63:0] case_total, control_total, inv_total, class_term;
        longint    joint_sum, marginal_sum;
        ccmi_out_t pending[$];

        function new();
            bit [63:0] m, r;
            for (int i = 0; i < (1 << TAB_BITS); i++)
            begin
                m = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
                r = 0;
                for (int k = 0; k < 32; k++)
                begin
                    m = (m * m) >> 30;
                    r = r << 1;
                    if (m >= (64'd1 << 31))
                    begin
                        r[0] = 1'b1;
                        m = m >> 1;
                    end
                end
                log2_tab[i] = r;
            end
            log2_tab[1 << TAB_BITS] = 64'd1 << 32;
        endfunction

        // Returns -p*ln(p) in Q8.40 for a Q0.32 probability.
        function bit [63:0] entropy_term(bit [63:0] p);
            int b;
            bit [63:0] f32, idx, rem, frac, nlog2, nln, hi, lo;
            if (p == 0)
                return 0;
            b = 31;
            while (p[b] == 1'b0)
                b--;
            f32 = (p - (64'd1 << b)) << (32 - b);
            idx = f32 >> TAB_SHIFT;
            rem = f32 & ((64'd1 << TAB_SHIFT) - 1);
            frac = log2_tab[idx] + (((log2_tab[idx + 1] - log2_tab[idx]) * rem) >> TAB_SHIFT);
            nlog2 = (64'(32 - b) << 32) - frac;
            nln = (nlog2 >> 32) * 64'(LN2_Q32) + (((nlog2 & SAT32) * 64'(LN2_Q32)) >> 32);
            hi = nln >> 32;
            lo = nln & SAT32;
            return ((p * hi) << 8) + ((p * lo) >> 24);
        endfunction

        function bit [63:0] fraction(bit [63:0] count);
            bit [63:0] p;
            p = count * inv_total;
            return (p > SAT32) ? SAT32 : p;
        endfunction

        function longint drain(longint acc, bit [63:0] term);
            longint r;
            r = acc - longint'(term);
            return (r < SUM_FLOOR) ? SUM_FLOOR : r;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, bit [63:0] value);
            bit [63:0] total;
            if (idx == REG_CASE_TOTAL)
                case_total = value & ((64'd1 << COUNT_BITS) - 1);
            else if (idx == REG_CONTROL_TOTAL)
                control_total = value & ((64'd1 << COUNT_BITS) - 1);
            else
                return;
            total = case_total + control_total;
            if (total == 0)
                inv_total = 0;
            else if (total == 1)
                inv_total = SAT32;
            else
                inv_total = (64'd1 << 32) / total;
            class_term = (entropy_term(fraction(case_total)) +
                          entropy_term(fraction(control_total))) >> 8;
            if (class_term > SAT32)
                class_term = SAT32;
        endfunction

        function void note_cell(ccmi_in_t w);
            bit [63:0] pc, pn, ps, mi;
            bit bad;
            longint r;
            ccmi_out_t e;
            pc = fraction(64'(w.case_count));
            pn = fraction(64'(w.control_count));
            ps = pc + pn;
            if (ps > SAT32)
                ps = SAT32;
            joint_sum = drain(joint_sum, entropy_term(pc));
            joint_sum = drain(joint_sum, entropy_term(pn));
            marginal_sum = drain(marginal_sum, entropy_term(ps));
            if (!w.last_cell)
                return;
            bad = (case_total + control_total) == 0;
            r = longint'(class_term << 8) + joint_sum - marginal_sum;
            if (bad || r < 0)
                mi = 0;
            else
            begin
                mi = 64'(r) >> 8;
                if (mi > SAT32)
                    mi = SAT32;
            end
            e.mutual_info = mi[31:0];
            e.bad_totals = bad;
            pending.push_back(e);
            joint_sum = 0;
            marginal_sum = 0;
        endfunction

        task check_word(ccmi_out_t w);
            ccmi_out_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected output word %h", w));
                return;
            end
            e = pending.pop_front();
            if (w.mutual_info !== e.mutual_info)
                report($sformatf("mutual_info %h, predicted %h", w.mutual_info, e.mutual_info));
            if (w.bad_totals !== e.bad_totals)
                report($sformatf("bad_totals %b, predicted %b", w.bad_totals, e.bad_totals));
        endtask
    endclass

    mi_tracker tracker = new();

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_word(out_word);
    end

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input bit [23:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, 64'(value));
        // The derivation keeps the input stalled; give it time to raise the stall.
        repeat (3) @(negedge clk);
        while (in_stall)
            @(negedge clk);
    endtask

    // Ends at the falling edge after the accept; the next word or drain_results
    // drops or replaces valid there.
    task automatic send_cell(input bit [23:0] cc, input bit [23:0] nc, input bit last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{case_count: cc, control_count: nc, last_cell: last};
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_cell('{case_count: cc, control_count: nc, last_cell: last});
        cells_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic bit [23:0] pick_count(bit [63:0] total);
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 30)
            return 24'($urandom_range(24'hFF_FFFF));
        if (sel < 38)
            return 24'hFF_FFFF;
        return 24'($urandom_range(32'(total > 24'hFF_FFFF ? 24'hFF_FFFF : total)));
    endfunction

    task automatic send_tables(input int n_cells);
        int left;
        int sz;
        left = n_cells;
        while (left > 0)
        begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
            if (sz > left)
                sz = left;
            for (int i = 0; i < sz; i++)
                send_cell(pick_count(tracker.case_total / 2 + 1),
                          pick_count(tracker.control_total / 2 + 1), i == sz - 1);
            left -= sz;
        end
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero totals: every table reports bad totals.
        send_cell(24'd5, 24'd7, 1'b0);
        send_cell(24'hFF_FFFF, 24'd0, 1'b1);
        drain_results();
        // A total of one saturates the reciprocal.
        write_reg(REG_CASE_TOTAL, 24'd1);
        send_cell(24'd1, 24'd0, 1'b1);
        send_cell(24'd0, 24'd0, 1'b0);
        send_cell(24'd3, 24'd2, 1'b1);
        drain_results();
        write_reg(REG_CONTROL_TOTAL, 24'hFF_FFFF);
        write_reg(REG_CASE_TOTAL, 24'hFF_FFFF);
        send_cell(24'hFF_FFFF, 24'd0, 1'b0);
        send_cell(24'd0, 24'hFF_FFFF, 1'b1);
        send_cell(24'h80_0000, 24'h7F_FFFF, 1'b0);
        send_cell(24'h7F_FFFF, 24'h80_0000, 1'b1);
        send_cell(24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
        drain_results();
        write_reg(REG_CASE_TOTAL, 24'd600);
        write_reg(REG_CONTROL_TOTAL, 24'd400);
        send_cell(24'd600, 24'd0, 1'b0);
        send_cell(24'd0, 24'd400, 1'b1);
        send_cell(24'd300, 24'd200, 1'b0);
        send_cell(24'd300, 24'd200, 1'b1);
        send_cell(24'd1000, 24'd1000, 1'b1);
        drain_results();

        phase = 0;
        while (cells_sent < 850)
        begin
            if (cells_sent < 300)
            begin
                tx_idle_pct = 11;
                rx_idle_pct = 85;
            end
            else if (cells_sent < 600)
            begin
                tx_idle_pct = 85;
                rx_idle_pct = 11;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(5))
                0: write_reg(REG_CASE_TOTAL, 24'd0);
                1: write_reg(REG_CONTROL_TOTAL, 24'hFF_FFFF);
                2: write_reg(REG_CASE_TOTAL, 24'($urandom_range(1, 50)));
                default: write_reg(REG_CASE_TOTAL, 24'($urandom_range(24'hFF_FFFF)));
            endcase
            write_reg(REG_CONTROL_TOTAL,
                      24'(($urandom_range(3) == 0) ? $urandom_range(0, 50)
                                                   : $urandom_range(24'hFF_FFFF)));
            if (phase == 2)
                rx_hold <= 400;
            send_tables(60);
            drain_results();
            phase++;
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: case_control_mutual_information.f
+incdir+design
design/ccmi_pkg.sv
design/ccmi_div.sv
design/ccmi_plogp.sv
design/ccmi_datapath.sv
design/ccmi_ctrl.sv
design/case_control_mutual_information.sv
tb/sv/tb_top.sv
